// ===== src/rc4d_pkg.sv =====
// ---------------------------------------------------------------------------
// rc4d_pkg: shared types, constants and microcode for the RC4-drop cipher
// Holds the control word layout, step codes and the microprogram ROM.
// ---------------------------------------------------------------------------
`default_nettype none

package rc4d_pkg;

   localparam int KEY_BYTES_DEF = 8;
   localparam int CSR_DATA_W    = 64;
   localparam int CSR_IDX_W     = 2;
   localparam int DISC_W        = 12;
   localparam logic [DISC_W-1:0] DISC_RESET = 12'd1024;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_KEY     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DISCARD = 2'd1;

   typedef logic [1:0] rsel_type;
   typedef logic [1:0] wsel_type;
   typedef logic [1:0] cond_type;
   typedef logic [3:0] upc_type;

   // read address sources
   localparam rsel_type RD_I  = 2'd0;   // S[i]
   localparam rsel_type RD_I1 = 2'd1;   // S[i+1]
   localparam rsel_type RD_J  = 2'd2;   // S[new j]
   localparam rsel_type RD_T  = 2'd3;   // S[si+sj]

   // write targets
   localparam wsel_type WR_NONE = 2'd0;
   localparam wsel_type WR_I    = 2'd1; // S[i] <= read word
   localparam wsel_type WR_J    = 2'd2; // S[j] <= si

   // jump conditions
   localparam cond_type JC_NEXT     = 2'd0;
   localparam cond_type JC_I_NLAST  = 2'd1; // i != 255
   localparam cond_type JC_CNT_ZERO = 2'd2;
   localparam cond_type JC_CNT_NONE = 2'd3; // count != 1

   // step codes
   localparam upc_type ST_K_CLR = 4'd0;
   localparam upc_type ST_K_RD  = 4'd1;
   localparam upc_type ST_K_SWP = 4'd2;
   localparam upc_type ST_K_WI  = 4'd3;
   localparam upc_type ST_K_WJ  = 4'd4;
   localparam upc_type ST_D_CHK = 4'd5;
   localparam upc_type ST_D_RD  = 4'd6;
   localparam upc_type ST_D_SWP = 4'd7;
   localparam upc_type ST_D_WI  = 4'd8;
   localparam upc_type ST_D_WJ  = 4'd9;
   localparam upc_type ST_G_RD  = 4'd10;
   localparam upc_type ST_G_SWP = 4'd11;
   localparam upc_type ST_G_WI  = 4'd12;
   localparam upc_type ST_G_WJ  = 4'd13;
   localparam upc_type ST_G_OUT = 4'd14;

   typedef struct packed {
      logic     clr;      // refill table, clear i/j, load drop count
      logic     inc_i;
      rsel_type rsel;
      logic     ld_si;    // si <= word, j <= j + word (+ key)
      logic     key_en;
      logic     ld_sj;
      wsel_type wsel;
      logic     dec_cnt;
      cond_type jc;
      upc_type  target;
      logic     done;     // deliver result, return to idle
   } ctrl_type;

   function automatic ctrl_type ucode_rom(input upc_type a);
      ctrl_type cw;
      cw = '0;
      case (a)
         ST_K_CLR: cw.clr = 1'b1;
         ST_K_RD:  cw.rsel = RD_I;
         ST_K_SWP: begin
            cw.ld_si  = 1'b1;
            cw.key_en = 1'b1;
            cw.rsel   = RD_J;
         end
         ST_K_WI:  cw.wsel = WR_I;
         ST_K_WJ:  begin
            cw.wsel   = WR_J;
            cw.inc_i  = 1'b1;
            cw.jc     = JC_I_NLAST;
            cw.target = ST_K_RD;
         end
         ST_D_CHK: begin
            cw.jc     = JC_CNT_ZERO;
            cw.target = ST_G_RD;
         end
         ST_D_RD:  begin
            cw.rsel  = RD_I1;
            cw.inc_i = 1'b1;
         end
         ST_D_SWP: begin
            cw.ld_si = 1'b1;
            cw.rsel  = RD_J;
         end
         ST_D_WI:  cw.wsel = WR_I;
         ST_D_WJ:  begin
            cw.wsel    = WR_J;
            cw.dec_cnt = 1'b1;
            cw.jc      = JC_CNT_NONE;
            cw.target  = ST_D_RD;
         end
         ST_G_RD:  begin
            cw.rsel  = RD_I1;
            cw.inc_i = 1'b1;
         end
         ST_G_SWP: begin
            cw.ld_si = 1'b1;
            cw.rsel  = RD_J;
         end
         ST_G_WI:  begin
            cw.wsel  = WR_I;
            cw.ld_sj = 1'b1;
         end
         ST_G_WJ:  begin
            cw.wsel = WR_J;
            cw.rsel = RD_T;
         end
         ST_G_OUT: cw.done = 1'b1;
         default:  cw.done = 1'b1;
      endcase
      return cw;
   endfunction

endpackage

`default_nettype wire

// ===== src/rc4_drop_stream_cipher.sv =====
// ---------------------------------------------------------------------------
// rc4_drop_stream_cipher: RC4 stream cipher with keystream drop
// Microcoded sequencer over a 256-byte permutation memory.
// ---------------------------------------------------------------------------
// Usage:
//  - req_* carries one word: a data byte, a restart flag and a last flag.
//    rsp_* returns the byte XORed with the next keystream byte, last copied.
//  - A word is taken only while the sequencer is idle; one word is in work
//    at a time. A plain word runs 5 microcode steps before rsp_valid rises,
//    and the next word is taken only once the sequencer is idle again, so
//    plain words are handled one at a time, limited by the single read
//    and single write port of the permutation memory.
//  - A word with restart set first runs the key schedule (1 + 4*256 steps),
//    then one check step and 4 steps per dropped byte, and then the steps
//    of a plain word.
//  - csr_we writes register csr_index (0: key, 1: drop count).
//    New values take effect at the next restart.
//  - Reset returns the table to identity, i = j = 0, key 0, drop count 1024.
//    The table is not swept: per-entry valid bits make an unwritten entry
//    read as its own index, and a restart clears them again in its first step.
//  - If rsp_ready is low, the result waits in the output register; the
//    sequencer holds in its final step until the register frees up.
// ---------------------------------------------------------------------------
`default_nettype none

module rc4_drop_stream_cipher #(
   parameter int KEY_BYTES = rc4d_pkg::KEY_BYTES_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [7:0]                      req_data_in,
   input  wire logic                            req_restart,
   input  wire logic                            req_last_in,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [7:0]                           rsp_data_out,
   output logic                                 rsp_last_out,
   input  wire logic                            csr_we,
   input  wire logic [rc4d_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [rc4d_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import rc4d_pkg::*;

   localparam int KEY_W  = 8 * KEY_BYTES;
   localparam int KIDX_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
   localparam logic [KIDX_W-1:0] KIDX_LAST = KIDX_W'(KEY_BYTES - 1);

   // config registers
   logic [KEY_W-1:0]  key_ff;
   logic [DISC_W-1:0] disc_ff;

   // sequencer
   logic     busy_ff;
   upc_type  upc_ff;
   ctrl_type cw;
   logic     take;
   logic     go;

   // datapath
   logic [7:0]        i_ff, j_ff, si_ff, sj_ff;
   logic [DISC_W-1:0] cnt_ff;
   logic [KIDX_W-1:0] kidx_ff;
   logic [7:0]        data_ff;
   logic              last_ff;

   // permutation memory with per-entry valid bits
   logic [7:0] perm_ff [256];
   logic [255:0] vld_ff;
   logic [7:0] rd_data_ff, rd_addr_ff;
   logic       rd_vld_ff;
   logic       fwd_ff;
   logic [7:0] rdv;
   logic [7:0] raddr, waddr, wdata;
   logic       we, rd_en;
   logic [7:0] kbyte, j_in, ks;

   logic       rsp_valid_ff;
   logic [7:0] rsp_data_ff;
   logic       rsp_last_ff;

   assign cw        = ucode_rom(upc_ff);
   assign req_ready = !busy_ff;
   assign go        = !rsp_valid_ff || rsp_ready;
   assign rd_en     = busy_ff && !cw.done;

   // invalid entry reads as its own index (identity fill)
   assign rdv   = rd_vld_ff ? rd_data_ff : rd_addr_ff;
   assign kbyte = cw.key_en ? key_ff[kidx_ff*8 +: 8] : 8'd0;
   assign j_in  = j_ff + rdv + kbyte;
   // S[j] is written in the same step that reads S[si+sj]
   assign ks    = fwd_ff ? si_ff : rdv;

   always_comb begin
      case (cw.rsel)
         RD_I:    raddr = i_ff;
         RD_I1:   raddr = i_ff + 8'd1;
         RD_J:    raddr = j_in;
         RD_T:    raddr = si_ff + sj_ff;
         default: raddr = i_ff;
      endcase
   end

   always_comb begin
      we    = 1'b0;
      waddr = i_ff;
      wdata = rdv;
      case (cw.wsel)
         WR_I: begin
            we    = busy_ff;
            waddr = i_ff;
            wdata = rdv;
         end
         WR_J: begin
            we    = busy_ff;
            waddr = j_ff;
            wdata = si_ff;
         end
         default: we = 1'b0;
      endcase
   end

   always_comb begin
      case (cw.jc)
         JC_I_NLAST:  take = (i_ff != 8'hFF);
         JC_CNT_ZERO: take = (cnt_ff == '0);
         JC_CNT_NONE: take = (cnt_ff != DISC_W'(1));
         default:     take = 1'b0;
      endcase
   end

   // memory
   always_ff @(posedge clock) begin
      if (we) begin
         perm_ff[waddr] <= wdata;
      end
      if (rd_en) begin
         rd_data_ff <= perm_ff[raddr];
         rd_addr_ff <= raddr;
         fwd_ff     <= (raddr == j_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (rd_en) begin
            rd_vld_ff <= vld_ff[raddr];
         end
         if (busy_ff && cw.clr) begin
            vld_ff <= '0;
         end else if (we) begin
            vld_ff[waddr] <= 1'b1;
         end
      end
   end

   // config port
   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff  <= '0;
         disc_ff <= DISC_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_KEY:     key_ff  <= csr_wdata[KEY_W-1:0];
            CSR_DISCARD: disc_ff <= csr_wdata[DISC_W-1:0];
            default:     ;
         endcase
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         upc_ff  <= ST_G_RD;
      end else if (!busy_ff) begin
         if (req_valid) begin
            busy_ff <= 1'b1;
            upc_ff  <= req_restart ? ST_K_CLR : ST_G_RD;
         end
      end else if (cw.done) begin
         if (go) begin
            busy_ff <= 1'b0;
         end
      end else begin
         upc_ff <= take ? cw.target : upc_ff + 4'd1;
      end
   end

   // index and scratch registers
   always_ff @(posedge clock) begin
      if (reset) begin
         i_ff    <= '0;
         j_ff    <= '0;
         cnt_ff  <= '0;
         kidx_ff <= '0;
      end else if (busy_ff) begin
         if (cw.clr) begin
            i_ff    <= '0;
            j_ff    <= '0;
            cnt_ff  <= disc_ff;
            kidx_ff <= '0;
         end
         if (cw.inc_i) begin
            i_ff <= i_ff + 8'd1;
         end
         if (cw.ld_si) begin
            j_ff <= j_in;
            if (cw.key_en) begin
               kidx_ff <= (kidx_ff == KIDX_LAST) ? '0 : kidx_ff + KIDX_W'(1);
            end
         end
         if (cw.dec_cnt) begin
            cnt_ff <= cnt_ff - DISC_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff && cw.ld_si) begin
         si_ff <= rdv;
      end
      if (busy_ff && cw.ld_sj) begin
         sj_ff <= rdv;
      end
      if (req_valid && req_ready) begin
         data_ff <= req_data_in;
         last_ff <= req_last_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (busy_ff && cw.done && go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff && cw.done && go) begin
         rsp_data_ff <= data_ff ^ ks;
         rsp_last_ff <= last_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data_out = rsp_data_ff;
   assign rsp_last_out = rsp_last_ff;

endmodule

`default_nettype wire

// ===== test/tb_rc4_drop_stream_cipher.sv =====
// ---------------------------------------------------------------------------
// tb_rc4_drop_stream_cipher: self-checking bench for the RC4-drop cipher
// A queue-fed driver offers data words, a predictor keyed from shadow copies
// of the CSRs computes each output word, and a monitor compares every
// accepted output against the oldest prediction. Directed words cover the
// unkeyed identity stream, zero and maximum drop, back-to-back restarts and
// key changes without restart; random messages follow under several keys.
// ---------------------------------------------------------------------------
module tb_rc4_drop_stream_cipher;
   import rc4d_pkg::*;

   // csr_index 2 and 3 decode to no register
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 2'd3;

   // worst run: every word slowed by stalls and gaps, every restart at the
   // largest drop; this bound covers that many times over
   localparam int RUN_LIMIT      = 1_500_000;
   localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
   localparam int HOLD_AFTER     = 80;    // words checked before the hold
   localparam int SETTLE_CYCLES  = 8;
   localparam int RANDOM_PHASES  = 6;
   localparam int PHASE_WORDS    = 240;

   typedef struct packed {
      logic [7:0] data;
      logic       restart;
      logic       last;
   } in_word_type;

   typedef struct packed {
      logic [7:0] data_out;
      logic       last_out;
   } out_word_type;

   // -----------------------------------------------------------------------
   // DUT signals; every input starts at a known value
   // -----------------------------------------------------------------------
   logic                  clock        = 1'b0;
   logic                  reset        = 1'b1;
   logic                  req_valid    = 1'b0;
   logic                  req_ready;
   logic [7:0]            req_data_in  = '0;
   logic                  req_restart  = 1'b0;
   logic                  req_last_in  = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready    = 1'b0;
   logic [7:0]            rsp_data_out;
   logic                  rsp_last_out;
   logic                  csr_we       = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index    = '0;
   logic [CSR_DATA_W-1:0] csr_wdata    = '0;

   rc4_drop_stream_cipher dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data_in  (req_data_in),
      .req_restart  (req_restart),
      .req_last_in  (req_last_in),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data_out (rsp_data_out),
      .rsp_last_out (rsp_last_out),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #2 clock = ~clock;

   // -----------------------------------------------------------------------
   // Bench state
   // -----------------------------------------------------------------------
   in_word_type  pending_words[$];     // words waiting to be offered
   out_word_type expected_out[$];      // predicted output words, oldest first
   int           fail_count    = 0;
   int           words_checked = 0;
   int           cycle_count   = 0;
   logic         quiet_tail    = 1'b0; // no idling on either side when set

   // predictor copy of the generator and of the two registers
   logic [7:0]          sbox [256];
   logic [7:0]          idx_i;
   logic [7:0]          idx_j;
   logic [63:0]         key_reg;
   logic [DISC_W-1:0]   drop_reg;

   // -----------------------------------------------------------------------
   // Predictor
   // -----------------------------------------------------------------------
   // One PRGA step: i++, j += S[i], swap, emit S[S[i] + S[j]].
   function automatic logic [7:0] advance_keystream();
      logic [7:0] t;
      logic [7:0] pick;
      idx_i       = idx_i + 8'd1;
      idx_j       = idx_j + sbox[idx_i];
      t           = sbox[idx_i];
      sbox[idx_i] = sbox[idx_j];
      sbox[idx_j] = t;
      pick        = sbox[idx_i] + sbox[idx_j];
      return sbox[pick];
   endfunction

   // Rekey: identity fill, 256 KSA rounds, clear i (j is kept), then drop.
   function automatic void schedule_key();
      logic [7:0] t;
      int         n;
      for (n = 0; n < 256; n++)
         sbox[n] = 8'(n);
      idx_j = 8'd0;
      for (n = 0; n < 256; n++) begin
         idx_j   = idx_j + sbox[n] + key_reg[8*(n % KEY_BYTES_DEF) +: 8];
         t       = sbox[n];
         sbox[n] = sbox[idx_j];
         sbox[idx_j] = t;
      end
      idx_i = 8'd0;
      for (n = 0; n < int'(drop_reg); n++)
         void'(advance_keystream());
   endfunction

   function automatic out_word_type cipher_word(input in_word_type w);
      out_word_type r;
      if (w.restart)
         schedule_key();
      r.data_out = w.data ^ advance_keystream();
      r.last_out = w.last;
      return r;
   endfunction

   // -----------------------------------------------------------------------
   // Driver: pops pending words, holds each until accepted, predicts at the
   // accepting edge. Each branch but the waiting one assigns req_valid once.
   // -----------------------------------------------------------------------
   int          req_gap = 0;
   in_word_type next_word;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap   <= 0;
      end else begin
         if (req_valid && req_ready)
            expected_out.push_back(cipher_word({req_data_in, req_restart, req_last_in}));

         if (req_valid && !req_ready) begin
            // still waiting: valid and payload stay put
         end else if (req_gap != 0) begin
            req_gap   <= req_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_words.size() != 0) begin
            if (!quiet_tail && $urandom_range(0, 5) == 0) begin
               // start an idle burst; req_gap extends it past this cycle
               req_gap   <= $urandom_range(0, 2);
               req_valid <= 1'b0;
            end else begin
               next_word   = pending_words.pop_front();
               req_valid   <= 1'b1;
               req_data_in <= next_word.data;
               req_restart <= next_word.restart;
               req_last_in <= next_word.last;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // -----------------------------------------------------------------------
   // Receiver ready: short random stalls plus one long hold-off, so the
   // output register fills and the block stops taking input words.
   // -----------------------------------------------------------------------
   int   rsp_stall  = 0;
   int   long_hold  = 0;
   logic hold_taken = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         rsp_stall  <= 0;
         long_hold  <= 0;
         hold_taken <= 1'b0;
      end else if (long_hold != 0) begin
         long_hold <= long_hold - 1;
         rsp_ready <= 1'b0;
      end else if (!hold_taken && words_checked >= HOLD_AFTER) begin
         long_hold  <= HOLD_CYCLES - 1;
         hold_taken <= 1'b1;
         rsp_ready  <= 1'b0;
      end else if (rsp_stall != 0) begin
         rsp_stall <= rsp_stall - 1;
         rsp_ready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
         rsp_stall <= $urandom_range(0, 2);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // -----------------------------------------------------------------------
   // Monitor: every accepted output word against the oldest prediction
   // -----------------------------------------------------------------------
   out_word_type want;

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_out.size() == 0) begin
            $error("unexpected output word: data_out %02h last_out %0b",
                   rsp_data_out, rsp_last_out);
            fail_count++;
         end else begin
            want = expected_out.pop_front();
            if (rsp_data_out !== want.data_out) begin
               $error("data_out: expected %02h, actual %02h", want.data_out, rsp_data_out);
               fail_count++;
            end
            if (rsp_last_out !== want.last_out) begin
               $error("last_out: expected %0b, actual %0b", want.last_out, rsp_last_out);
               fail_count++;
            end
         end
         words_checked <= words_checked + 1;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // -----------------------------------------------------------------------
   // Stimulus helpers. Queues are filled at the falling edge, away from the
   // driver and monitor, which work on the rising edge.
   // -----------------------------------------------------------------------
   task automatic push_word(input logic [7:0] data, input logic restart, input logic last);
      pending_words.push_back('{data: data, restart: restart, last: last});
   endtask

   // CSR write; shadow copy follows the same decode (spare indexes ignored)
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_KEY:     key_reg  = value;
         CSR_DISCARD: drop_reg = value[DISC_W-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // block is idle once nothing is queued, offered or outstanding
   task automatic wait_drained();
      do
         @(negedge clock);
      while (pending_words.size() != 0 || req_valid || expected_out.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Mostly well-formed messages (optional restart on the first word, last on
   // the final one); about one chunk in ten is a stray word with random flags.
   task automatic random_phase(input int count);
      int   left;
      int   len;
      int   n;
      logic rekey_msg;
      left = count;
      while (left > 0) begin
         if ($urandom_range(0, 9) == 0) begin
            push_word(8'($urandom), 1'($urandom), 1'($urandom));
            left--;
         end else begin
            len       = $urandom_range(1, 32);
            rekey_msg = ($urandom_range(0, 2) == 0);
            for (n = 0; n < len && left > 0; n++) begin
               push_word(8'($urandom), rekey_msg && n == 0, n == len - 1);
               left--;
            end
         end
      end
   endtask

   // -----------------------------------------------------------------------
   // Test sequence
   // -----------------------------------------------------------------------
   initial begin : sequencer
      logic [63:0]       rnd_key;
      logic [DISC_W-1:0] rnd_drop;
      int                p;

      for (p = 0; p < 256; p++)
         sbox[p] = 8'(p);
      idx_i    = 8'd0;
      idx_j    = 8'd0;
      key_reg  = '0;
      drop_reg = DISC_RESET;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // unkeyed stream straight from the identity table, data extremes
      push_word(8'h00, 1'b0, 1'b0);
      push_word(8'hFF, 1'b0, 1'b0);
      push_word(8'hA5, 1'b0, 1'b1);
      push_word(8'h5A, 1'b0, 1'b0);
      push_word(8'h0F, 1'b0, 1'b1);
      // rekey with the reset key and the default drop of 1024
      push_word(8'hF0, 1'b1, 1'b0);
      push_word(8'h00, 1'b0, 1'b0);
      push_word(8'hFF, 1'b0, 1'b1);
      wait_drained();

      // all-ones key, zero drop (junk above bit 11 must be masked),
      // two restarts back to back
      write_reg(CSR_KEY, '1);
      write_reg(CSR_DISCARD, {{(CSR_DATA_W-DISC_W){1'b1}}, {DISC_W{1'b0}}});
      push_word(8'hFF, 1'b1, 1'b1);
      push_word(8'h3C, 1'b1, 1'b0);
      push_word(8'hC3, 1'b0, 1'b1);
      wait_drained();

      // distinct key bytes, largest drop; spare indexes must not land anywhere
      write_reg(CSR_KEY, 64'h0123_4567_89AB_CDEF);
      write_reg(CSR_DISCARD, {{(CSR_DATA_W-DISC_W){1'b0}}, {DISC_W{1'b1}}});
      write_reg(CSR_SPARE_LO, '1);
      write_reg(CSR_SPARE_HI, {$urandom, $urandom});
      push_word(8'h81, 1'b1, 1'b0);
      push_word(8'h7E, 1'b0, 1'b1);
      wait_drained();

      // new key mid-stream: old table keeps running until the next restart
      write_reg(CSR_KEY, {$urandom, $urandom});
      write_reg(CSR_DISCARD, 64'd1);
      push_word(8'h55, 1'b0, 1'b0);
      push_word(8'hAA, 1'b0, 1'b1);
      push_word(8'h96, 1'b1, 1'b0);
      push_word(8'h69, 1'b0, 1'b1);
      wait_drained();

      // random messages under several settings; drops stay small except for
      // the default value, since each restart's run time grows with the drop
      for (p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            1:       rnd_key = '0;
            3:       rnd_key = '1;
            default: rnd_key = {$urandom, $urandom};
         endcase
         case (p)
            2:       rnd_drop = DISC_RESET;
            4:       rnd_drop = '0;
            default: rnd_drop = DISC_W'($urandom_range(1, 48));
         endcase
         write_reg(CSR_KEY, rnd_key);
         write_reg(CSR_DISCARD, {$urandom, 20'($urandom), rnd_drop});
         if (p == RANDOM_PHASES - 1)
            quiet_tail = 1'b1;
         random_phase(PHASE_WORDS);
         wait_drained();
      end

      if (fail_count == 0 && expected_out.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
